>>> sv/spfm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Serial flash programming master: shared definitions
// Types, command constants and register reset values used by every module.
// ---------------------------------------------------------------------------
package spfm_pkg;

    localparam int P_WAIT_BITS  = 20;
    localparam int Q_DEPTH      = 2;

    localparam logic [7:0] C_PREFIX     = 8'hAC;
    localparam logic [7:0] C_ECHO       = 8'h53;
    localparam logic [7:0] C_ERASE      = 8'h80;
    localparam logic [7:0] C_READ       = 8'h20;
    localparam logic [7:0] C_LOAD       = 8'h40;
    localparam logic [7:0] C_WRITE      = 8'h4C;
    localparam logic [9:0] C_PAGE_HI    = 10'h300;
    localparam logic [7:0] C_PAGE_MID   = 8'hF0;
    localparam logic [7:0] C_WORD_LO    = 8'h0F;
    localparam logic [4:0] C_BIT_LAST   = 5'd31;

    localparam logic [7:0]  R_SETUP      = 8'd15;
    localparam logic [7:0]  R_HIGH       = 8'd75;
    localparam logic [7:0]  R_LOW        = 8'd90;
    localparam logic [19:0] R_ERASE_WAIT = 20'd9000;
    localparam logic [19:0] R_PAGE_WAIT  = 20'd4500;

    typedef enum logic [2:0] {
        OP_ENABLE = 3'd0,
        OP_ERASE  = 3'd1,
        OP_READ   = 3'd2,
        OP_LOAD   = 3'd3,
        OP_WRITE  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        CFG_SETUP      = 3'd0,
        CFG_HIGH       = 3'd1,
        CFG_LOW        = 3'd2,
        CFG_ERASE_WAIT = 3'd3,
        CFG_PAGE_WAIT  = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_WAIT  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [7:0]  setup_ticks;
        logic [7:0]  high_ticks;
        logic [7:0]  low_ticks;
        logic [19:0] erase_wait_ticks;
        logic [19:0] page_wait_ticks;
    } t_cfg;

    typedef struct packed {
        logic        start;
        t_op         op;
        logic [31:0] cmd;
        logic        miso;
    } t_item;

    typedef struct packed {
        logic       sclk;
        logic       mosi;
        logic       busy;
        logic       done;
        logic [7:0] read_byte;
        logic       enable_ok;
    } t_result;

endpackage
`default_nettype wire

>>> sv/spfm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Serial flash programming master: front end
// Classifies each tick beat and assembles the 32-bit command for a start.
// ---------------------------------------------------------------------------
module spfm_front
    import spfm_pkg::*;
(
    input  wire logic       i_start_req,
    input  wire logic [2:0] i_operation,
    input  wire logic       i_high_byte_select,
    input  wire logic [9:0] i_word_address,
    input  wire logic [7:0] i_load_data,
    input  wire logic       i_miso,
    output t_item           o_item
);

    logic [7:0] w_b3;
    logic [7:0] w_b2;
    logic [7:0] w_b1;
    logic [7:0] w_b0;
    logic       w_known;
    logic [9:0] w_hi_bits;

    assign w_hi_bits = (i_word_address & C_PAGE_HI) >> 8;

    always_comb begin
        w_b3    = '0;
        w_b2    = '0;
        w_b1    = '0;
        w_b0    = '0;
        w_known = 1'b1;
        unique case (i_operation)
            OP_ENABLE: begin
                w_b3 = C_PREFIX;
                w_b2 = C_ECHO;
            end
            OP_ERASE: begin
                w_b3 = C_PREFIX;
                w_b2 = C_ERASE;
            end
            OP_READ: begin
                w_b3 = C_READ | {4'd0, i_high_byte_select, 3'd0};
                w_b2 = w_hi_bits[7:0];
                w_b1 = i_word_address[7:0];
            end
            OP_LOAD: begin
                w_b3 = C_LOAD | {4'd0, i_high_byte_select, 3'd0};
                w_b1 = i_word_address[7:0] & C_WORD_LO;
                w_b0 = i_load_data;
            end
            OP_WRITE: begin
                w_b3 = C_WRITE;
                w_b2 = w_hi_bits[7:0];
                w_b1 = i_word_address[7:0] & C_PAGE_MID;
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign o_item.start = i_start_req & w_known;
    assign o_item.op    = w_known ? t_op'(i_operation) : OP_ENABLE;
    assign o_item.cmd   = {w_b3, w_b2, w_b1, w_b0};
    assign o_item.miso  = i_miso;

endmodule
`default_nettype wire

>>> sv/spfm_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Serial flash programming master: item queue
// Short first-in first-out buffer between the front end and the engine.
// ---------------------------------------------------------------------------
module spfm_queue
    import spfm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_item
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_item            r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW:0]     r_count;
    logic             w_push;
    logic             w_pop;

    assign o_push_ready = (r_count != (QAW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr + QAW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == QAW'(Q_DEPTH - 1)) ? '0 : r_rd + QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/spfm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// Serial flash programming master: bit engine
// Runs the setup, high, low and wait phases one tick beat at a time and
// registers the resulting line levels and status.
// ---------------------------------------------------------------------------
module spfm_back
    import spfm_pkg::*;
#(
    parameter int WAIT_COUNTER_BITS = P_WAIT_BITS
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_item_valid,
    output logic       o_item_ready,
    input  wire t_item i_item,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output t_result    o_res
);

    localparam int W    = WAIT_COUNTER_BITS;
    localparam int CMPW = ((W > 20) ? W : 20) + 1;
    localparam logic [CMPW-1:0] TICK_MAX = CMPW'((64'd1 << W) - 64'd1);

    t_phase      r_phase, n_phase;
    logic [W-1:0] r_tick, n_tick;
    logic [4:0]  r_bit, n_bit;
    logic [31:0] r_cmd, n_cmd;
    logic [15:0] r_rx, n_rx;
    t_op         r_op, n_op;
    logic [7:0]  r_last, n_last;
    logic        r_echo, n_echo;
    logic        r_out_valid, n_out_valid;
    t_result     r_res, n_res;

    logic            w_step;
    logic            w_cur_bit;
    logic [CMPW-1:0] w_tick_next;
    logic [19:0]     w_wait_raw;
    logic [CMPW-1:0] w_wait_ext;
    logic [CMPW-1:0] w_wait_len;
    logic            w_setup_end;
    logic            w_high_end;
    logic            w_low_end;
    logic            w_wait_end;
    logic            w_echo_new;

    assign w_step       = i_item_valid & (~r_out_valid | i_out_ready);
    assign o_item_ready = w_step;
    assign o_out_valid  = r_out_valid;
    assign o_res        = r_res;

    assign w_cur_bit   = r_cmd[C_BIT_LAST - r_bit];
    assign w_tick_next = CMPW'(r_tick) + CMPW'(1);
    assign w_wait_raw  = (r_op == OP_ERASE) ? i_cfg.erase_wait_ticks :
                         (r_op == OP_WRITE) ? i_cfg.page_wait_ticks : '0;
    assign w_wait_ext  = CMPW'(w_wait_raw);
    assign w_wait_len  = (w_wait_ext > TICK_MAX) ? TICK_MAX : w_wait_ext;
    assign w_setup_end = (w_tick_next >= CMPW'(i_cfg.setup_ticks));
    assign w_high_end  = (w_tick_next >= CMPW'(i_cfg.high_ticks));
    assign w_low_end   = (w_tick_next >= CMPW'(i_cfg.low_ticks));
    assign w_wait_end  = (w_tick_next >= w_wait_len);
    assign w_echo_new  = (r_op == OP_ENABLE) ? (r_rx[15:8] == C_ECHO) : r_echo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_last      <= '0;
            r_echo      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_last      <= n_last;
            r_echo      <= n_echo;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_rx  <= n_rx;
        r_op  <= n_op;
        r_res <= n_res;
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_cmd       = r_cmd;
        n_rx        = r_rx;
        n_op        = r_op;
        n_last      = r_last;
        n_echo      = r_echo;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~i_out_ready;
        if (w_step) begin
            n_out_valid = 1'b1;
            n_res       = '0;
            unique case (r_phase)
                PH_SETUP: begin
                    n_res.busy = 1'b1;
                    n_res.mosi = w_cur_bit;
                    if (w_setup_end) begin
                        n_tick  = '0;
                        n_phase = PH_HIGH;
                    end else begin
                        n_tick = r_tick + W'(1);
                    end
                end
                PH_HIGH: begin
                    n_res.busy = 1'b1;
                    n_res.sclk = 1'b1;
                    n_res.mosi = w_cur_bit;
                    if (w_high_end) begin
                        n_rx    = {r_rx[14:0], i_item.miso};
                        n_tick  = '0;
                        n_phase = PH_LOW;
                    end else begin
                        n_tick = r_tick + W'(1);
                    end
                end
                PH_LOW: begin
                    n_res.busy = 1'b1;
                    n_res.mosi = w_cur_bit;
                    if (w_low_end) begin
                        n_tick = '0;
                        if (r_bit == C_BIT_LAST) begin
                            if (w_wait_len == '0) begin
                                n_last     = r_rx[7:0];
                                n_echo     = w_echo_new;
                                n_res.done = 1'b1;
                                n_phase    = PH_IDLE;
                            end else begin
                                n_phase = PH_WAIT;
                            end
                        end else begin
                            n_bit   = r_bit + 5'd1;
                            n_phase = PH_SETUP;
                        end
                    end else begin
                        n_tick = r_tick + W'(1);
                    end
                end
                PH_WAIT: begin
                    n_res.busy = 1'b1;
                    if (w_wait_end) begin
                        n_last     = r_rx[7:0];
                        n_echo     = w_echo_new;
                        n_res.done = 1'b1;
                        n_tick     = '0;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_tick = r_tick + W'(1);
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (i_item.start) begin
                        n_cmd   = i_item.cmd;
                        n_op    = i_item.op;
                        n_bit   = '0;
                        n_tick  = '0;
                        n_rx    = '0;
                        n_phase = PH_SETUP;
                    end
                end
            endcase
            n_res.read_byte = n_last;
            n_res.enable_ok = n_echo;
        end
    end

endmodule
`default_nettype wire

>>> sv/serial_flash_programming_master_unit.sv
// A tick beat is written into the item queue when it is accepted; its result is
// registered in the bit engine's output register when the engine takes it from the queue.
// Throughput: one tick beat per cycle while the result channel is not stalled.
// Reset (synchronous, active low) idles the engine, empties the queue and
// output register, clears the read byte and enable flag and loads the
// default timing registers.
`default_nettype none
// ---------------------------------------------------------------------------
// Serial flash programming master
// Serial programming bit engine with timing registers, item queue and
// registered result stage.
// ---------------------------------------------------------------------------
module serial_flash_programming_master_unit
    import spfm_pkg::*;
#(
    parameter int WAIT_COUNTER_BITS = P_WAIT_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_start_req,
    input  wire logic [2:0]  i_operation,
    input  wire logic        i_high_byte_select,
    input  wire logic [9:0]  i_word_address,
    input  wire logic [7:0]  i_load_data,
    input  wire logic        i_miso,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_sclk,
    output logic             o_mosi,
    output logic             o_busy_res,
    output logic             o_done_res,
    output logic [7:0]       o_read_byte,
    output logic             o_enable_ok
);

    t_cfg    r_cfg;
    t_item   w_front_item;
    t_item   w_q_item;
    logic    w_q_valid;
    logic    w_q_ready;
    t_result w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.setup_ticks      <= R_SETUP;
            r_cfg.high_ticks       <= R_HIGH;
            r_cfg.low_ticks        <= R_LOW;
            r_cfg.erase_wait_ticks <= R_ERASE_WAIT;
            r_cfg.page_wait_ticks  <= R_PAGE_WAIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SETUP:      r_cfg.setup_ticks      <= i_cfg_data[7:0];
                CFG_HIGH:       r_cfg.high_ticks       <= i_cfg_data[7:0];
                CFG_LOW:        r_cfg.low_ticks        <= i_cfg_data[7:0];
                CFG_ERASE_WAIT: r_cfg.erase_wait_ticks <= i_cfg_data;
                CFG_PAGE_WAIT:  r_cfg.page_wait_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    spfm_front u_front (
        .i_start_req        (i_start_req),
        .i_operation        (i_operation),
        .i_high_byte_select (i_high_byte_select),
        .i_word_address     (i_word_address),
        .i_load_data        (i_load_data),
        .i_miso             (i_miso),
        .o_item             (w_front_item)
    );

    spfm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_in_valid),
        .o_push_ready (o_in_ready),
        .i_push_item  (w_front_item),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_item   (w_q_item)
    );

    spfm_back #(
        .WAIT_COUNTER_BITS (WAIT_COUNTER_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (w_q_valid),
        .o_item_ready (w_q_ready),
        .i_item       (w_q_item),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_res        (w_res)
    );

    assign o_sclk      = w_res.sclk;
    assign o_mosi      = w_res.mosi;
    assign o_busy_res  = w_res.busy;
    assign o_done_res  = w_res.done;
    assign o_read_byte = w_res.read_byte;
    assign o_enable_ok = w_res.enable_ok;

    a_sclk_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_sclk) |-> o_busy_res)
        else $error("serial clock driven high outside a command");

    a_done_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_busy_res && !o_sclk))
        else $error("completion reported outside a low or wait tick");

    a_full_has_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> w_q_valid)
        else $error("queue refuses beats while holding none");

endmodule
`default_nettype wire

>>> bench/spfm_tick_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial flash programming master: tick checker
// Watches the register, tick and result channels. It keeps its own copy of
// the timing registers and of the bit engine, works out the result of every
// accepted tick beat, and compares each result beat against the oldest one
// still waiting.
// ---------------------------------------------------------------------------
module spfm_tick_checker
    import spfm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [19:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic        i_start_req,
    input  wire logic [2:0]  i_operation,
    input  wire logic        i_high_byte_select,
    input  wire logic [9:0]  i_word_address,
    input  wire logic [7:0]  i_load_data,
    input  wire logic        i_miso,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_sclk,
    input  wire logic        i_mosi,
    input  wire logic        i_busy_res,
    input  wire logic        i_done_res,
    input  wire logic [7:0]  i_read_byte,
    input  wire logic        i_enable_ok,
    output int               o_fail_count,
    output int               o_pending
);

    localparam longint unsigned WAIT_MAX = (64'd1 << P_WAIT_BITS) - 64'd1;

    t_cfg                   timing;
    t_phase                 eng_phase;
    logic [P_WAIT_BITS-1:0] eng_ticks;
    logic [4:0]             eng_bit;
    logic [31:0]            eng_cmd;
    logic [31:0]            eng_rx;
    t_op                    eng_op;
    logic [7:0]             eng_read;
    logic                   eng_echo;

    t_result expected_ticks[$];
    t_result predicted;
    t_result wanted;

    function automatic logic [31:0] command_word(t_op op, logic hl, logic [9:0] addr,
                                                 logic [7:0] data);
        logic [7:0] b3;
        logic [7:0] b2;
        logic [7:0] b1;
        logic [7:0] b0;
        b3 = 8'h00;
        b2 = 8'h00;
        b1 = 8'h00;
        b0 = 8'h00;
        case (op)
            OP_ENABLE: begin
                b3 = C_PREFIX;
                b2 = C_ECHO;
            end
            OP_ERASE: begin
                b3 = C_PREFIX;
                b2 = C_ERASE;
            end
            OP_READ: begin
                b3 = C_READ | {4'b0, hl, 3'b0};
                b2 = 8'((addr & C_PAGE_HI) >> 8);
                b1 = addr[7:0];
            end
            OP_LOAD: begin
                b3 = C_LOAD | {4'b0, hl, 3'b0};
                b1 = addr[7:0] & C_WORD_LO;
                b0 = data;
            end
            default: begin
                b3 = C_WRITE;
                b2 = 8'((addr & C_PAGE_HI) >> 8);
                b1 = addr[7:0] & C_PAGE_MID;
            end
        endcase
        return {b3, b2, b1, b0};
    endfunction

    function automatic longint unsigned wait_len();
        longint unsigned w;
        w = 0;
        if (eng_op == OP_ERASE) begin
            w = timing.erase_wait_ticks;
        end else if (eng_op == OP_WRITE) begin
            w = timing.page_wait_ticks;
        end
        if (w > WAIT_MAX) begin
            w = WAIT_MAX;
        end
        return w;
    endfunction

    function automatic bit ends_now(longint unsigned len);
        return (64'(eng_ticks) + 64'd1) >= len;
    endfunction

    task automatic finish_command(output logic done);
        eng_read = eng_rx[7:0];
        if (eng_op == OP_ENABLE) begin
            eng_echo = (eng_rx[15:8] == C_ECHO);
        end
        done = 1'b1;
        eng_phase = PH_IDLE;
        eng_ticks = '0;
    endtask

    task automatic predict_tick(input logic start, input logic [2:0] op, input logic hl,
                                input logic [9:0] addr, input logic [7:0] data,
                                input logic miso, output t_result res);
        logic cur;
        logic done;
        res = '0;
        done = 1'b0;
        cur = eng_cmd[5'd31 - eng_bit];
        case (eng_phase)
            PH_SETUP: begin
                res.busy = 1'b1;
                res.mosi = cur;
                if (ends_now(timing.setup_ticks)) begin
                    eng_ticks = '0;
                    eng_phase = PH_HIGH;
                end else begin
                    eng_ticks++;
                end
            end
            PH_HIGH: begin
                res.busy = 1'b1;
                res.sclk = 1'b1;
                res.mosi = cur;
                if (ends_now(timing.high_ticks)) begin
                    eng_rx = {eng_rx[30:0], miso};
                    eng_ticks = '0;
                    eng_phase = PH_LOW;
                end else begin
                    eng_ticks++;
                end
            end
            PH_LOW: begin
                res.busy = 1'b1;
                res.mosi = cur;
                if (ends_now(timing.low_ticks)) begin
                    eng_ticks = '0;
                    if (eng_bit == C_BIT_LAST) begin
                        if (wait_len() == 0) begin
                            finish_command(done);
                        end else begin
                            eng_phase = PH_WAIT;
                        end
                    end else begin
                        eng_bit++;
                        eng_phase = PH_SETUP;
                    end
                end else begin
                    eng_ticks++;
                end
            end
            PH_WAIT: begin
                res.busy = 1'b1;
                if (ends_now(wait_len())) begin
                    finish_command(done);
                end else begin
                    eng_ticks++;
                end
            end
            default: begin
                eng_phase = PH_IDLE;
                if (start && op <= OP_WRITE) begin
                    eng_cmd = command_word(t_op'(op), hl, addr, data);
                    eng_op = t_op'(op);
                    eng_bit = '0;
                    eng_ticks = '0;
                    eng_rx = '0;
                    eng_phase = PH_SETUP;
                end
            end
        endcase
        res.done = done;
        res.read_byte = eng_read;
        res.enable_ok = eng_echo;
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            timing.setup_ticks = R_SETUP;
            timing.high_ticks = R_HIGH;
            timing.low_ticks = R_LOW;
            timing.erase_wait_ticks = R_ERASE_WAIT;
            timing.page_wait_ticks = R_PAGE_WAIT;
            eng_phase = PH_IDLE;
            eng_ticks = '0;
            eng_bit = '0;
            eng_cmd = '0;
            eng_rx = '0;
            eng_op = OP_ENABLE;
            eng_read = '0;
            eng_echo = 1'b0;
            expected_ticks.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_SETUP:      timing.setup_ticks = i_cfg_data[7:0];
                    CFG_HIGH:       timing.high_ticks = i_cfg_data[7:0];
                    CFG_LOW:        timing.low_ticks = i_cfg_data[7:0];
                    CFG_ERASE_WAIT: timing.erase_wait_ticks = i_cfg_data;
                    CFG_PAGE_WAIT:  timing.page_wait_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_tick(i_start_req, i_operation, i_high_byte_select, i_word_address,
                             i_load_data, i_miso, predicted);
                expected_ticks.push_back(predicted);
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_ticks.size() == 0) begin
                    $display("%0t: result beat with nothing expected: expected none, actual %0h",
                             $time, {i_sclk, i_mosi, i_busy_res, i_done_res, i_read_byte,
                                     i_enable_ok});
                    o_fail_count++;
                end else begin
                    wanted = expected_ticks.pop_front();
                    check_field("sclk", 8'(wanted.sclk), 8'(i_sclk));
                    check_field("mosi", 8'(wanted.mosi), 8'(i_mosi));
                    check_field("busy_res", 8'(wanted.busy), 8'(i_busy_res));
                    check_field("done_res", 8'(wanted.done), 8'(i_done_res));
                    check_field("read_byte", wanted.read_byte, i_read_byte);
                    check_field("enable_ok", 8'(wanted.enable_ok), 8'(i_enable_ok));
                end
            end
        end
        o_pending = expected_ticks.size();
    end

endmodule

>>> bench/serial_flash_programming_master_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Serial flash programming master: testbench top
// Drives time ticks carrying programming commands and target replies, writes
// the timing registers between commands, varies the handshake pressure on
// both sides and reports the verdict from the tick checker.
// ---------------------------------------------------------------------------
module serial_flash_programming_master_unit_tb;
    import spfm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 400;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        start_req = 1'b0;
    logic [2:0]  operation = '0;
    logic        high_byte_select = 1'b0;
    logic [9:0]  word_address = '0;
    logic [7:0]  load_data = '0;
    logic        miso = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        sclk;
    logic        mosi;
    logic        busy_res;
    logic        done_res;
    logic [7:0]  read_byte;
    logic        enable_ok;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int items_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;

    int setup_len = R_SETUP;
    int high_len = R_HIGH;
    int low_len = R_LOW;
    int erase_wait = R_ERASE_WAIT;
    int page_wait = R_PAGE_WAIT;

    serial_flash_programming_master_unit u_top (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_start_req        (start_req),
        .i_operation        (operation),
        .i_high_byte_select (high_byte_select),
        .i_word_address     (word_address),
        .i_load_data        (load_data),
        .i_miso             (miso),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_sclk             (sclk),
        .o_mosi             (mosi),
        .o_busy_res         (busy_res),
        .o_done_res         (done_res),
        .o_read_byte        (read_byte),
        .o_enable_ok        (enable_ok)
    );

    spfm_tick_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_start_req        (start_req),
        .i_operation        (operation),
        .i_high_byte_select (high_byte_select),
        .i_word_address     (word_address),
        .i_load_data        (load_data),
        .i_miso             (miso),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_sclk             (sclk),
        .i_mosi             (mosi),
        .i_busy_res         (busy_res),
        .i_done_res         (done_res),
        .i_read_byte        (read_byte),
        .i_enable_ok        (enable_ok),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // The long hold-off is counted here so that the sender keeps offering beats meanwhile.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task automatic send_tick(input logic start, input logic [2:0] op, input logic hl,
                             input logic [9:0] addr, input logic [7:0] data, input logic m);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        start_req <= start;
        operation <= op;
        high_byte_select <= hl;
        word_address <= addr;
        load_data <= data;
        miso <= m;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_noise(input int count);
        repeat (count) begin
            send_tick(1'b0, 3'($urandom_range(7)), 1'($urandom_range(1)),
                      10'($urandom_range(1023)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SETUP:      setup_len = data[7:0];
            CFG_HIGH:       high_len = data[7:0];
            CFG_LOW:        low_len = data[7:0];
            CFG_ERASE_WAIT: erase_wait = data;
            CFG_PAGE_WAIT:  page_wait = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // The target's reply bit is held on the last clock-high tick of each bit; other
    // ticks carry random levels on the data line.
    task automatic run_command(input logic [2:0] op, input logic hl, input logic [9:0] addr,
                               input logic [7:0] data, input logic [31:0] reply);
        int s;
        int h;
        int l;
        int per_bit;
        int total;
        int bit_idx;
        logic m;
        s = (setup_len > 0) ? setup_len : 1;
        h = (high_len > 0) ? high_len : 1;
        l = (low_len > 0) ? low_len : 1;
        per_bit = s + h + l;
        total = 32 * per_bit;
        if (op == OP_ERASE) begin
            total += erase_wait;
        end else if (op == OP_WRITE) begin
            total += page_wait;
        end
        send_tick(1'b1, op, hl, addr, data, 1'($urandom_range(1)));
        for (int t = 0; t < total; t++) begin
            bit_idx = t / per_bit;
            if (bit_idx < 32 && (t % per_bit) == s + h - 1) begin
                m = reply[31 - bit_idx];
            end else begin
                m = 1'($urandom_range(1));
            end
            send_tick(1'($urandom_range(19) == 0), 3'($urandom_range(7)),
                      1'($urandom_range(1)), 10'($urandom_range(1023)),
                      8'($urandom_range(255)), m);
        end
    endtask

    initial begin
        send_idle_pct = 11;
        recv_idle_pct = 88;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_noise(3);
        for (int code = OP_SPARE_LO; code <= OP_SPARE_HI; code++) begin
            send_tick(1'b1, 3'(code), 1'b1, 10'h3FF, 8'hFF, 1'b1);
        end

        drain();
        write_reg(CFG_SETUP, 20'hFFF00);
        write_reg(CFG_HIGH, 20'hFFF00);
        write_reg(CFG_LOW, 20'hFFF00);
        write_reg(CFG_ERASE_WAIT, 20'h00000);
        write_reg(CFG_PAGE_WAIT, 20'h00000);
        for (int code = CFG_SPARE_LO; code <= CFG_SPARE_HI; code++) begin
            write_reg(3'(code), 20'($urandom));
        end
        run_command(OP_ENABLE, 1'b0, 10'h000, 8'h00, {16'hFFFF, C_ECHO, 8'hA5});

        hold_left = HOLD_OFF_CYCLES;
        send_noise(12);

        send_idle_pct = 88;
        recv_idle_pct = 11;
        drain();
        write_reg(CFG_ERASE_WAIT, 20'd3);
        run_command(OP_ERASE, 1'b1, 10'h3FF, 8'hFF, 32'hFFFF_FFFF);
        drain();
        write_reg(CFG_ERASE_WAIT, 20'hFFFFF);
        write_reg(CFG_PAGE_WAIT, 20'hFFFFF);
        run_command(OP_LOAD, 1'b1, 10'h3C7, 8'h81, $urandom);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        drain();
        write_reg(CFG_PAGE_WAIT, 20'd1);
        run_command(OP_WRITE, 1'b0, 10'h2AA, 8'hA5, {16'h0000, C_ECHO, 8'hC3});

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
